// ===== hdl/depth_grid_triangulator_macros.svh =====
// ----------------------------------------------------------------------------
// Depth grid triangulator assertion macros
// Shorthands for the concurrent checks of the top level, clocked on clk and
// held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef DEPTH_GRID_TRIANGULATOR_MACROS_SVH
`define DEPTH_GRID_TRIANGULATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DGT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check that cons holds in the cycle after ante.
`define DGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/dgt_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth grid triangulator package
// Widths, register codes, reset values, queue types and the corner test.
// ----------------------------------------------------------------------------
package dgt_pkg;

  localparam int DEPTH_W    = 24;
  localparam int IDX_W      = 22;
  localparam int SIZE_W     = 12;
  localparam int STEP_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_FLOOR = 2'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0]         GRID_WIDTH_RST    = 12'd2048;
  localparam logic [SIZE_W-1:0]         GRID_HEIGHT_RST   = 12'd2048;
  localparam logic [STEP_W-1:0]         MAX_STEP_RST      = 23'd320;
  localparam logic signed [DEPTH_W-1:0] INVALID_FLOOR_RST = -24'sd159984;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Corner order of the two triangles of a kept quad
  localparam int SEQ_W = 3;
  localparam logic [SEQ_W-1:0] SEQ_TL_A = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_BR_A = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_TR   = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_BR_B = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_TL_B = 3'd4;
  localparam logic [SEQ_W-1:0] SEQ_BL   = 3'd5;

  typedef struct packed {
    logic [IDX_W-1:0] tl;
    logic [IDX_W-1:0] bl;
  } quad_entry_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } qstat_t;

  // |a - b| <= lim
  function automatic logic close_enough(input logic signed [DEPTH_W-1:0] a,
                                        input logic signed [DEPTH_W-1:0] b,
                                        input logic [STEP_W-1:0] lim);
    logic signed [DEPTH_W:0] diff;
    logic [DEPTH_W:0]        mag;
    diff = $signed({a[DEPTH_W-1], a}) - $signed({b[DEPTH_W-1], b});
    mag  = diff[DEPTH_W] ? $unsigned(-diff) : $unsigned(diff);
    return mag <= {{(DEPTH_W + 1 - STEP_W){1'b0}}, lim};
  endfunction

endpackage

// ===== hdl/depth_grid_triangulator.sv =====
// ----------------------------------------------------------------------------
// Depth grid triangulator
// Turns a raster stream of grid depths into triangle corner indices, two
// triangles for every 2x2 quad whose corners are present and close in depth.
// ----------------------------------------------------------------------------
//
//   channel   direction  signals                                  content
//   s_axis    in         tvalid tready tdata[23:0]                depth
//   m_axis    out        tvalid tready tdata[23:0] tlast          vertex_index, last
//   cfg       in         valid ready index[1:0] data[23:0]        register writes
//
// The front end takes one depth beat per clock while the quad queue has room;
// a dropped quad, or a pixel in the first row or column, costs nothing more.
// A kept quad gives six output beats, one per corner, set by the
// corner sequencer of the back end; the queue is four quads deep.
// A beat passes the quad test and index stages and the queue before its corners.
// rst is synchronous and active high; the row memory is never cleared.
// Output stalls back up through the queue into s_axis_tready only when full.
//
`include "depth_grid_triangulator_macros.svh"

module depth_grid_triangulator #(
  parameter int MAX_WIDTH  = dgt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dgt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // depth [23:0]
  input  logic [dgt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_index [21:0], zero [23:22]
  output logic [dgt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dgt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dgt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dgt_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  logic [SIZE_W-1:0]         grid_width;
  logic [SIZE_W-1:0]         grid_height;
  logic [STEP_W-1:0]         max_step;
  logic signed [DEPTH_W-1:0] invalid_floor;

  logic [WW-1:0]             width_use;
  logic [HW-1:0]             height_use;

  logic                      q_push;
  logic                      q_pop;
  quad_entry_t               q_in;
  quad_entry_t               q_head;
  qstat_t                    q_stat;
  logic [IDX_W-1:0]          out_index;

  // Writes land straight in the registers, so the channel never holds off
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= GRID_WIDTH_RST;
      grid_height   <= GRID_HEIGHT_RST;
      max_step      <= MAX_STEP_RST;
      invalid_floor <= INVALID_FLOOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    grid_width    <= cfg_data[SIZE_W-1:0];
        REG_GRID_HEIGHT:   grid_height   <= cfg_data[SIZE_W-1:0];
        REG_MAX_STEP:      max_step      <= cfg_data[STEP_W-1:0];
        REG_INVALID_FLOOR: invalid_floor <= $signed(cfg_data[DEPTH_W-1:0]);
      endcase
    end
  end

  // Saturate the grid size into 2 .. MAX
  always_comb begin
    if (grid_width < SIZE_W'(2)) begin
      width_use = WW'(2);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      width_use = WW'(MAX_WIDTH);
    end else begin
      width_use = WW'(grid_width);
    end
    if (grid_height < SIZE_W'(2)) begin
      height_use = HW'(2);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      height_use = HW'(MAX_HEIGHT);
    end else begin
      height_use = HW'(grid_height);
    end
  end

  // Front end: position, row memory, quad test, corner base indices
  dgt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .depth         ($signed(s_axis_tdata[DEPTH_W-1:0])),
    .width_use     (width_use),
    .height_use    (height_use),
    .max_step      (max_step),
    .invalid_floor (invalid_floor),
    .q_full        (q_stat.full),
    .push          (q_push),
    .push_entry    (q_in)
  );

  // Queue of kept quads; lets the front run on while corners drain
  dgt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_stat)
  );

  // Back end: six corners per quad into the output register
  dgt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_stat.empty),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (out_index),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_index);

  // Never write a full queue, never read an empty one
  `DGT_ASSERT_NOW(a_push_room, q_push, !q_stat.full)
  `DGT_ASSERT_NOW(a_pop_avail, q_pop, !q_stat.empty)
  // Input holds off only because the queue is full
  `DGT_ASSERT_NOW(a_stall_cause, !s_axis_tready, q_stat.full)
  // A lone write grows the fill level by one
  `DGT_ASSERT_NEXT(a_fill_step, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule

// ===== hdl/dgt_front.sv =====
// ----------------------------------------------------------------------------
// Depth grid triangulator front end
// Tracks grid position, keeps one row of depths, tests each completed quad
// and pushes the corner indices of kept quads into the queue.
// ----------------------------------------------------------------------------
module dgt_front #(
  parameter int MAX_WIDTH  = dgt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dgt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dgt_pkg::DEPTH_W-1:0]   depth,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]     width_use,
  input  logic [$clog2(MAX_HEIGHT + 1)-1:0]    height_use,
  input  logic [dgt_pkg::STEP_W-1:0]           max_step,
  input  logic signed [dgt_pkg::DEPTH_W-1:0]   invalid_floor,
  input  logic                                 q_full,
  output logic                                 push,
  output dgt_pkg::quad_entry_t                 push_entry
);
  import dgt_pkg::*;

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int CCMP_W = CW + 2;
  localparam int RCMP_W = RW + 2;

  logic               adv;
  logic               accept;

  // Position counters and row memory
  logic [CW-1:0]      col_cnt;
  logic [RW-1:0]      row_cnt;
  logic               col_wrap;
  logic [RCMP_W-1:0]  row_pre;
  logic [CW-1:0]      col_cur;
  logic [RW-1:0]      row_cur;
  logic [CCMP_W-1:0]  col_inc;
  logic [RCMP_W-1:0]  row_inc;
  logic [DEPTH_W-1:0] row_store [MAX_WIDTH];
  logic [DEPTH_W-1:0] up_q;
  logic [DEPTH_W-1:0] left_depth;

  // Quad test stage
  logic               s1_valid;
  logic               s1_quad;
  logic [DEPTH_W-1:0] s1_depth;
  logic [DEPTH_W-1:0] s1_left;
  logic [DEPTH_W-1:0] s1_upleft;
  logic [CW-1:0]      s1_x;
  logic [RW-1:0]      s1_y;
  logic signed [DEPTH_W-1:0] z0, z1, z2, z3;
  logic               s1_keep;
  logic [RW+WW-1:0]   s1_prod;

  // Index stage
  logic               s2_valid;
  logic               s2_keep;
  logic [IDX_W-1:0]   s2_prod;
  logic [IDX_W-1:0]   s2_x;
  logic [IDX_W-1:0]   s2_xw;

  assign adv      = !(s2_valid && s2_keep && q_full);
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // Start a new row or frame first when the size shrank under the counters
  always_comb begin
    col_wrap = CCMP_W'(col_cnt) >= CCMP_W'(width_use);
    row_pre  = col_wrap ? RCMP_W'(row_cnt) + RCMP_W'(1) : RCMP_W'(row_cnt);
    col_cur  = col_wrap ? '0 : col_cnt;
    row_cur  = (row_pre >= RCMP_W'(height_use)) ? '0 : RW'(row_pre);
    col_inc  = CCMP_W'(col_cur) + CCMP_W'(1);
    row_inc  = RCMP_W'(row_cur) + RCMP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      left_depth <= '0;
    end else if (accept) begin
      left_depth <= depth;
      if (col_inc >= CCMP_W'(width_use)) begin
        col_cnt <= '0;
        row_cnt <= (row_inc >= RCMP_W'(height_use)) ? '0 : RW'(row_inc);
      end else begin
        col_cnt <= CW'(col_inc);
        row_cnt <= row_cur;
      end
    end
  end

  // Read the entry before overwriting it with this beat's depth
  always_ff @(posedge clk) begin
    if (accept) begin
      up_q               <= row_store[col_cur];
      row_store[col_cur] <= depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_upleft <= '0;
    end else if (adv) begin
      s1_valid <= accept;
      if (accept) begin
        s1_upleft <= up_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_quad  <= (row_cur != '0) && (col_cur != '0);
      s1_depth <= depth;
      s1_left  <= left_depth;
      s1_x     <= col_cur - CW'(1);
      s1_y     <= row_cur - RW'(1);
    end
  end

  always_comb begin
    z0 = $signed(s1_upleft);
    z1 = $signed(up_q);
    z2 = $signed(s1_depth);
    z3 = $signed(s1_left);
    s1_keep = s1_quad &&
              (z0 > invalid_floor) && (z1 > invalid_floor) &&
              (z2 > invalid_floor) && (z3 > invalid_floor) &&
              close_enough(z0, z1, max_step) && close_enough(z1, z2, max_step) &&
              close_enough(z0, z2, max_step) && close_enough(z0, z3, max_step) &&
              close_enough(z1, z3, max_step) && close_enough(z2, z3, max_step);
    s1_prod = (RW + WW)'(s1_y) * (RW + WW)'(width_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_keep  <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s2_keep  <= s1_valid && s1_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod <= IDX_W'(s1_prod);
      s2_x    <= IDX_W'(s1_x);
      s2_xw   <= IDX_W'(s1_x) + IDX_W'(width_use);
    end
  end

  assign push          = s2_valid && s2_keep && !q_full;
  assign push_entry.tl = s2_prod + s2_x;
  assign push_entry.bl = s2_prod + s2_xw;

endmodule

// ===== hdl/dgt_queue.sv =====
// ----------------------------------------------------------------------------
// Depth grid triangulator quad queue
// Small first-in first-out store of kept quads between front and back.
// ----------------------------------------------------------------------------
module dgt_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dgt_pkg::quad_entry_t push_entry,
  input  logic                 pop,
  output dgt_pkg::quad_entry_t head,
  output dgt_pkg::qstat_t      status
);
  import dgt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  quad_entry_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign status.count = count;

endmodule

// ===== hdl/dgt_back.sv =====
// ----------------------------------------------------------------------------
// Depth grid triangulator back end
// Walks each queued quad through its six triangle corners into a registered
// output stage.
// ----------------------------------------------------------------------------
module dgt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  dgt_pkg::quad_entry_t            head,
  input  logic                            q_empty,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dgt_pkg::IDX_W-1:0]       out_index,
  output logic                            out_last
);
  import dgt_pkg::*;

  logic             busy;
  logic [SEQ_W-1:0] step;
  logic [IDX_W-1:0] cur_tl;
  logic [IDX_W-1:0] cur_bl;
  logic             out_free;
  logic             emit;
  logic [IDX_W-1:0] corner;

  assign out_free = !out_valid || out_ready;
  assign emit     = busy && out_free;
  // Take the next quad while idle, or alongside the final corner
  assign pop      = !q_empty && (!busy || (emit && step == SEQ_BL));

  always_comb begin
    case (step)
      SEQ_TL_A: corner = cur_tl;
      SEQ_BR_A: corner = cur_bl + IDX_W'(1);
      SEQ_TR:   corner = cur_tl + IDX_W'(1);
      SEQ_BR_B: corner = cur_bl + IDX_W'(1);
      SEQ_TL_B: corner = cur_tl;
      SEQ_BL:   corner = cur_bl;
      default:  corner = cur_tl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= SEQ_TL_A;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        step <= SEQ_TL_A;
      end else if (emit) begin
        if (step == SEQ_BL) begin
          busy <= 1'b0;
        end
        step <= step + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_tl <= head.tl;
      cur_bl <= head.bl;
    end
    if (emit) begin
      out_index <= corner;
      out_last  <= (step == SEQ_BL);
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth grid triangulator testbench
// Streams raster depth grids into the triangulator and checks every corner
// beat against a behavioural model of the quad test, held in a scoreboard.
// Covers corner cases first, then rows at the saturated 2048-column width,
// then random surfaces under changing grid sizes, step limits and floors.
// ----------------------------------------------------------------------------
module tb_top;
  import dgt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 10;
  localparam int Z_MIN = -8388608;
  localparam int Z_MAX = 8388607;

  typedef struct {
    logic [IDX_W-1:0] index;
    bit               last;
  } corner_t;

  // Model of the quad test plus the queue of corner beats still owed.
  class quad_scoreboard;
    logic signed [DEPTH_W-1:0] prev_row [MAX_WIDTH_DEF];
    logic signed [DEPTH_W-1:0] left_z, upper_left_z;
    int unsigned               col, row;
    logic [SIZE_W-1:0]         width_reg, height_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [DEPTH_W-1:0] floor_reg;
    corner_t                   owed_corners [$];
    int                        errors, kept_quads, dropped_quads, corners_seen;

    function new();
      foreach (prev_row[i]) prev_row[i] = '0;
      left_z = '0;
      upper_left_z = '0;
      col = 0;
      row = 0;
      width_reg = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      step_reg = MAX_STEP_RST;
      floor_reg = INVALID_FLOOR_RST;
      errors = 0;
      kept_quads = 0;
      dropped_quads = 0;
      corners_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH:    width_reg = data[SIZE_W-1:0];
        REG_GRID_HEIGHT:   height_reg = data[SIZE_W-1:0];
        REG_MAX_STEP:      step_reg = data[STEP_W-1:0];
        REG_INVALID_FLOOR: floor_reg = data[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned size_in_use(logic [SIZE_W-1:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit near(logic signed [DEPTH_W-1:0] a, logic signed [DEPTH_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d <= longint'(step_reg);
    endfunction

    function bit quad_fits(logic signed [DEPTH_W-1:0] z0, logic signed [DEPTH_W-1:0] z1,
                           logic signed [DEPTH_W-1:0] z2, logic signed [DEPTH_W-1:0] z3);
      if (!(z0 > floor_reg && z1 > floor_reg && z2 > floor_reg && z3 > floor_reg))
        return 0;
      return near(z0, z1) && near(z1, z2) && near(z0, z2) &&
             near(z0, z3) && near(z1, z3) && near(z2, z3);
    endfunction

    function int pending();
      return owed_corners.size();
    endfunction

    // Advance the model by one accepted depth beat.
    function void note_depth(logic [IN_DATA_W-1:0] raw);
      logic signed [DEPTH_W-1:0] z, above;
      int unsigned w, h, tl, bl;
      int unsigned order [6];
      corner_t c;
      w = size_in_use(width_reg, MAX_WIDTH_DEF);
      h = size_in_use(height_reg, MAX_HEIGHT_DEF);
      z = raw[DEPTH_W-1:0];
      // a shrunk grid forces a fresh row or frame before this pixel
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      above = prev_row[col];
      if (row >= 1 && col >= 1) begin
        if (quad_fits(upper_left_z, above, z, left_z)) begin
          tl = (row - 1) * w + (col - 1);
          bl = tl + w;
          order = '{tl, bl + 1, tl + 1, bl + 1, tl, bl};
          for (int k = 0; k < 6; k++) begin
            c.index = order[k][IDX_W-1:0];
            c.last = (k == 5);
            owed_corners.insert(owed_corners.size(), c);
          end
          kept_quads++;
        end else begin
          dropped_quads++;
        end
      end
      upper_left_z = above;
      left_z = z;
      prev_row[col] = z;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_corner(logic [OUT_DATA_W-1:0] data, logic tlast);
      corner_t c;
      corners_seen++;
      if (owed_corners.size() == 0) begin
        $error("unexpected corner beat: vertex_index %0d last %0d", data[IDX_W-1:0], tlast);
        errors++;
        return;
      end
      c = owed_corners.pop_front();
      if (data[IDX_W-1:0] !== c.index) begin
        $error("vertex_index: expected %0d, got %0d", c.index, data[IDX_W-1:0]);
        errors++;
      end
      if (tlast !== c.last) begin
        $error("last: expected %0d, got %0d", c.last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic [IN_DATA_W-1:0]    s_axis_tdata;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  quad_scoreboard board;
  bit  src_quiet, sink_quiet;
  int  cycles = 0;
  int  depth_beats, reg_writes;

  depth_grid_triangulator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),   // depth [23:0]
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // vertex_index [21:0], zero [23:22]
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int draw_pause(bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // Drive one depth beat; enter and leave at a falling edge with tvalid held.
  task automatic feed_depth(input int z);
    int gap;
    logic [IN_DATA_W-1:0] beat;
    beat = IN_DATA_W'(z);
    gap = draw_pause(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= beat;
    do @(posedge clk); while (!s_axis_tready);
    board.note_depth(beat);
    depth_beats++;
    @(negedge clk);
  endtask

  task automatic feed4(input int a, input int b, input int c, input int d);
    feed_depth(a);
    feed_depth(b);
    feed_depth(c);
    feed_depth(d);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input int w, input int h, input int step, input int floor_z);
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_MAX_STEP, CFG_DATA_W'(step));
    write_reg(REG_INVALID_FLOOR, CFG_DATA_W'(floor_z));
  endtask

  // Drop tvalid and wait until every owed corner has left, plus the pipeline depth
  // so that dropped quads still in flight have drained too.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sink side: random back-pressure, check every corner beat.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_pause(sink_quiet);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_corner(m_axis_tdata, m_axis_tlast);
      @(negedge clk);
    end
  end

  initial begin
    int w, h, step, floor_z, base, spread, sel;
    int z;
    board = new();
    depth_beats = 0;
    reg_writes = 0;
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Corner cases on 2x2 grids: width 0 and height 1 both saturate to 2, so
    // every four beats make one frame with a single quad.
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(1));
    // default step and floor: a difference of exactly the step keeps the quad,
    // a corner sitting on the floor drops it
    feed4(0, 320, 0, 320);
    feed4(-159984, -159984, -159984, -159984);
    drain();
    write_all(0, 1, 0, Z_MIN);
    feed4(Z_MIN, Z_MIN + 1, Z_MIN + 1, Z_MIN + 1);
    feed4(Z_MIN + 1, Z_MIN + 1, Z_MIN + 1, Z_MIN + 1);
    feed4(Z_MAX, Z_MAX, Z_MAX, Z_MAX - 1);
    drain();
    // widest step: a difference equal to it passes, the span from Z_MIN + 1 to Z_MAX fails
    write_all(0, 1, 23'h7FFFFF, -1);
    feed4(0, Z_MAX, 0, Z_MAX);
    drain();
    write_reg(REG_INVALID_FLOOR, CFG_DATA_W'(Z_MIN));
    feed4(Z_MAX, Z_MIN + 1, Z_MAX, Z_MIN + 1);
    drain();

    // Wide rows: oversize registers saturate to 2048 columns. Fill the first
    // sixteen columns of row 0, narrow the grid so the next beat opens row 1,
    // then widen it again part-way along so lower corners sit 2048 further on.
    // A hole sits on the floor; one point lies just above it but far away.
    write_all(4095, 4095, 320, -159984);
    src_quiet = 1'b1;
    sink_quiet = 1'b1;
    for (int k = 0; k < 16; k++) begin
      if (k == 5)
        feed_depth(-159984);
      else
        feed_depth(int'($urandom_range(0, 320)));
    end
    drain();
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(9));
    for (int k = 0; k < 4; k++) begin
      if (k == 2)
        feed_depth(-159983);
      else
        feed_depth(int'($urandom_range(0, 320)));
    end
    drain();
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(4095));
    for (int k = 0; k < 6; k++) begin
      feed_depth(int'($urandom_range(0, 320)));
    end
    drain();

    // Random surfaces. Phases often end mid-row or mid-frame, so a new, smaller
    // size forces a row or frame wrap; widths stay within the columns written
    // above, so every row entry read here holds a depth.
    for (int ph = 0; ph < 5; ph++) begin
      sel = $urandom_range(0, 3);
      w = (sel == 0) ? int'($urandom_range(0, 1)) : int'($urandom_range(2, 9));
      h = ($urandom_range(0, 5) == 0) ? 4095 : int'($urandom_range(0, 6));
      case ($urandom_range(0, 4))
        0: step = 0;
        1: step = $urandom_range(1, 64);
        2: step = 320;
        3: step = 23'h7FFFFF;
        default: step = $urandom_range(0, 23'h7FFFFF);
      endcase
      case ($urandom_range(0, 7))
        0, 1: floor_z = Z_MIN;
        2, 3: floor_z = -159984;
        4: floor_z = Z_MAX;
        default: floor_z = -int'($urandom_range(0, 8388608));
      endcase
      write_all(w, h, step, floor_z);
      src_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      base = int'($urandom_range(0, 8100000)) - 100000;
      spread = (step < 200000) ? step : 200000;
      for (int k = 0; k < 12; k++) begin
        sel = $urandom_range(0, 15);
        if (sel == 0)
          z = floor_z;
        else if (sel == 1)
          z = int'($urandom);
        else
          z = base + int'($urandom_range(0, spread));
        feed_depth(z);
      end
      drain();
    end

    $display("Streamed %0d depth beats with %0d register writes; %0d quads kept, %0d dropped.",
             depth_beats, reg_writes, board.kept_quads, board.dropped_quads);
    $display("Checked %0d corner beats, including rows at the saturated 2048-column width.",
             board.corners_seen);
    if (board.errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
